[src/cau_pkg.sv]
package cau_pkg;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * DATA_W;
   localparam int WIDE_W = PROD_W + 2;
   localparam int QUO_W = 2 * FRAC_W + 1;
   localparam int DIV_STEPS = QUO_W;

   localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(64'sh7FFF_FFFF);
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = -WIDE_W'(64'sh8000_0000);
   localparam logic [DATA_W-1:0] RES_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] RES_MIN = 32'h8000_0000;
   localparam logic signed [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) <<< (FRAC_W - 1);

   // one divider lane: partial remainder, numerator bits still to shift in, divisor
   typedef struct packed {
      logic [PROD_W-1:0] rem;
      logic [FRAC_W-1:0] low;
      logic [PROD_W-1:0] den;
      logic [QUO_W-1:0]  quo;
   } lane_type;

   typedef struct packed {
      logic              is_div;
      logic              dz;
      logic              neg_re;
      logic              neg_im;
      logic              ovf_re;
      logic              ovf_im;
      logic [DATA_W-1:0] res_re;
      logic [DATA_W-1:0] res_im;
      logic              sat;
   } side_type;

   typedef struct packed {
      logic [DATA_W-1:0] res_re;
      logic [DATA_W-1:0] res_im;
      logic              div_zero;
      logic              saturated;
   } rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0] val;
      logic              sat;
   } clamp_type;

   function automatic clamp_type clamp_wide(input logic signed [WIDE_W-1:0] v);
      clamp_type c;
      c.sat = 1'b0;
      c.val = v[DATA_W-1:0];
      if (v > WIDE_MAX) begin
         c.sat = 1'b1;
         c.val = RES_MAX;
      end else if (v < WIDE_MIN) begin
         c.sat = 1'b1;
         c.val = RES_MIN;
      end
      return c;
   endfunction

   // restoring division step, one quotient bit
   function automatic lane_type lane_step(input lane_type l);
      lane_type n;
      logic [PROD_W:0] trial;
      logic [PROD_W:0] diff;
      n = l;
      trial = {l.rem, l.low[FRAC_W-1]};
      diff = trial - {1'b0, l.den};
      if (trial >= {1'b0, l.den}) begin
         n.rem = diff[PROD_W-1:0];
         n.quo = {l.quo[QUO_W-2:0], 1'b1};
      end else begin
         n.rem = trial[PROD_W-1:0];
         n.quo = {l.quo[QUO_W-2:0], 1'b0};
      end
      n.low = {l.low[FRAC_W-2:0], 1'b0};
      return n;
   endfunction

   // quotient carries one extra bit, round half away from zero then apply sign
   function automatic clamp_type div_result(input logic [QUO_W-1:0] quo, input logic neg,
                                            input logic ovf);
      clamp_type c;
      logic [QUO_W:0] sum;
      logic [QUO_W-1:0] mag;
      logic [QUO_W-1:0] neg_mag;
      sum = {1'b0, quo} + (QUO_W+1)'(1);
      mag = sum[QUO_W:1];
      neg_mag = QUO_W'(0) - mag;
      c.sat = 1'b0;
      c.val = mag[DATA_W-1:0];
      if (ovf) begin
         c.sat = 1'b1;
         c.val = neg ? RES_MIN : RES_MAX;
      end else if (!neg) begin
         if (mag > {1'b0, RES_MAX}) begin
            c.sat = 1'b1;
            c.val = RES_MAX;
         end
      end else if (mag > {1'b0, RES_MIN}) begin
         c.sat = 1'b1;
         c.val = RES_MIN;
      end else begin
         c.val = neg_mag[DATA_W-1:0];
      end
      return c;
   endfunction

endpackage

[src/cau_req_if.sv]
interface cau_req_if import cau_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               operation;
   logic signed [DATA_W-1:0] a_re;
   logic signed [DATA_W-1:0] a_im;
   logic signed [DATA_W-1:0] b_re;
   logic signed [DATA_W-1:0] b_im;

   modport source(output valid, operation, a_re, a_im, b_re, b_im, input ready);
   modport sink(input valid, operation, a_re, a_im, b_re, b_im, output ready);
endinterface

[src/cau_rsp_if.sv]
interface cau_rsp_if import cau_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] res_re;
   logic signed [DATA_W-1:0] res_im;
   logic                     div_zero;
   logic                     saturated;

   modport source(output valid, res_re, res_im, div_zero, saturated, input ready);
   modport sink(input valid, res_re, res_im, div_zero, saturated, output ready);
endinterface

[src/cau_prep.sv]
module cau_prep import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   cau_req_if.sink  req_chan,
   output logic     out_valid,
   output side_type out_side,
   output lane_type out_re,
   output lane_type out_im
);

   logic                     s0_valid_ff;
   logic [1:0]               s0_op_ff;
   logic signed [DATA_W-1:0] s0_a_ff, s0_b_ff, s0_c_ff, s0_d_ff;

   logic                     s1_valid_ff;
   logic [1:0]               s1_op_ff;
   side_type                 s1_side_ff, s1_side_in;
   logic signed [PROD_W-1:0] s1_ac_ff, s1_bd_ff, s1_ad_ff, s1_bc_ff, s1_cc_ff, s1_dd_ff;
   logic signed [PROD_W-1:0] ac_in, bd_in, ad_in, bc_in, cc_in, dd_in;
   logic signed [WIDE_W-1:0] sum_re, sum_im;
   clamp_type                as_re, as_im;

   logic                     s2_valid_ff;
   side_type                 s2_side_ff, s2_side_in;
   logic [PROD_W-1:0]        s2_mag_re_ff, s2_mag_im_ff, s2_den_ff;
   logic [PROD_W-1:0]        mag_re_in, mag_im_in, den_in;
   logic signed [WIDE_W-1:0] mul_re, mul_im, num_re, num_im, neg_re, neg_im;
   clamp_type                ml_re, ml_im;

   logic                     s3_valid_ff;
   side_type                 s3_side_ff, s3_side_in;
   lane_type                 s3_re_ff, s3_im_ff;

   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_chan.valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage 1: products, add and subtract
   assign ac_in = s0_a_ff * s0_c_ff;
   assign bd_in = s0_b_ff * s0_d_ff;
   assign ad_in = s0_a_ff * s0_d_ff;
   assign bc_in = s0_b_ff * s0_c_ff;
   assign cc_in = s0_c_ff * s0_c_ff;
   assign dd_in = s0_d_ff * s0_d_ff;

   assign sum_re = (s0_op_ff == OP_SUB) ? WIDE_W'(s0_a_ff) - WIDE_W'(s0_c_ff)
                                        : WIDE_W'(s0_a_ff) + WIDE_W'(s0_c_ff);
   assign sum_im = (s0_op_ff == OP_SUB) ? WIDE_W'(s0_b_ff) - WIDE_W'(s0_d_ff)
                                        : WIDE_W'(s0_b_ff) + WIDE_W'(s0_d_ff);
   assign as_re = clamp_wide(sum_re);
   assign as_im = clamp_wide(sum_im);

   always_comb begin
      s1_side_in = '0;
      s1_side_in.is_div = (s0_op_ff == OP_DIV);
      s1_side_in.dz = (s0_op_ff == OP_DIV) && (s0_c_ff == '0) && (s0_d_ff == '0);
      if (s1_side_in.dz) begin
         s1_side_in.res_re = s0_a_ff;
         s1_side_in.res_im = s0_b_ff;
      end else begin
         s1_side_in.res_re = as_re.val;
         s1_side_in.res_im = as_im.val;
         s1_side_in.sat = (s0_op_ff == OP_ADD || s0_op_ff == OP_SUB) &&
                          (as_re.sat || as_im.sat);
      end
   end

   // stage 2: rounded product sums, divide numerators and divisor magnitude
   assign mul_re = (WIDE_W'(s1_ac_ff) - WIDE_W'(s1_bd_ff) + ROUND_HALF) >>> FRAC_W;
   assign mul_im = (WIDE_W'(s1_ad_ff) + WIDE_W'(s1_bc_ff) + ROUND_HALF) >>> FRAC_W;
   assign ml_re = clamp_wide(mul_re);
   assign ml_im = clamp_wide(mul_im);

   assign num_re = WIDE_W'(s1_ac_ff) + WIDE_W'(s1_bd_ff);
   assign num_im = WIDE_W'(s1_bc_ff) - WIDE_W'(s1_ad_ff);
   assign neg_re = -num_re;
   assign neg_im = -num_im;
   assign mag_re_in = num_re[WIDE_W-1] ? neg_re[PROD_W-1:0] : num_re[PROD_W-1:0];
   assign mag_im_in = num_im[WIDE_W-1] ? neg_im[PROD_W-1:0] : num_im[PROD_W-1:0];
   assign den_in = $unsigned(s1_cc_ff) + $unsigned(s1_dd_ff);

   always_comb begin
      s2_side_in = s1_side_ff;
      s2_side_in.neg_re = num_re[WIDE_W-1];
      s2_side_in.neg_im = num_im[WIDE_W-1];
      if (s1_op_ff == OP_MUL) begin
         s2_side_in.res_re = ml_re.val;
         s2_side_in.res_im = ml_im.val;
         s2_side_in.sat = ml_re.sat || ml_im.sat;
      end
   end

   // stage 3: quotient overflow check and divider lane setup
   always_comb begin
      s3_side_in = s2_side_ff;
      s3_side_in.ovf_re = {{FRAC_W{1'b0}}, s2_mag_re_ff[PROD_W-1:FRAC_W]} >= s2_den_ff;
      s3_side_in.ovf_im = {{FRAC_W{1'b0}}, s2_mag_im_ff[PROD_W-1:FRAC_W]} >= s2_den_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_op_ff <= req_chan.operation;
         s0_a_ff <= req_chan.a_re;
         s0_b_ff <= req_chan.a_im;
         s0_c_ff <= req_chan.b_re;
         s0_d_ff <= req_chan.b_im;

         s1_op_ff <= s0_op_ff;
         s1_side_ff <= s1_side_in;
         s1_ac_ff <= ac_in;
         s1_bd_ff <= bd_in;
         s1_ad_ff <= ad_in;
         s1_bc_ff <= bc_in;
         s1_cc_ff <= cc_in;
         s1_dd_ff <= dd_in;

         s2_side_ff <= s2_side_in;
         s2_mag_re_ff <= mag_re_in;
         s2_mag_im_ff <= mag_im_in;
         s2_den_ff <= den_in;

         s3_side_ff <= s3_side_in;
         s3_re_ff <= '{rem: {{FRAC_W{1'b0}}, s2_mag_re_ff[PROD_W-1:FRAC_W]},
                       low: s2_mag_re_ff[FRAC_W-1:0], den: s2_den_ff, quo: '0};
         s3_im_ff <= '{rem: {{FRAC_W{1'b0}}, s2_mag_im_ff[PROD_W-1:FRAC_W]},
                       low: s2_mag_im_ff[FRAC_W-1:0], den: s2_den_ff, quo: '0};
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_side = s3_side_ff;
   assign out_re = s3_re_ff;
   assign out_im = s3_im_ff;

endmodule

[src/cau_divider.sv]
module cau_divider import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  side_type in_side,
   input  lane_type in_re,
   input  lane_type in_im,
   output logic     out_valid,
   output side_type out_side,
   output lane_type out_re,
   output lane_type out_im
);

   logic [DIV_STEPS-1:0] valid_ff;
   side_type             side_ff [DIV_STEPS];
   lane_type             re_ff [DIV_STEPS];
   lane_type             im_ff [DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DIV_STEPS-2:0], in_valid};
      end
   end

   // one quotient bit per stage for both lanes
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         re_ff[0] <= lane_step(in_re);
         im_ff[0] <= lane_step(in_im);
         for (int i = 1; i < DIV_STEPS; i++) begin
            side_ff[i] <= side_ff[i-1];
            re_ff[i] <= lane_step(re_ff[i-1]);
            im_ff[i] <= lane_step(im_ff[i-1]);
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_side = side_ff[DIV_STEPS-1];
   assign out_re = re_ff[DIV_STEPS-1];
   assign out_im = im_ff[DIV_STEPS-1];

endmodule

[src/cau_out.sv]
module cau_out import cau_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  side_type  in_side,
   input  lane_type  in_re,
   input  lane_type  in_im,
   output logic      en,
   cau_rsp_if.source rsp_chan
);

   clamp_type dv_re, dv_im;
   rsp_type   res_in;
   rsp_type   out_ff, skid_ff;
   logic      out_valid_ff, skid_valid_ff;
   logic      take;

   assign dv_re = div_result(in_re.quo, in_side.neg_re, in_side.ovf_re);
   assign dv_im = div_result(in_im.quo, in_side.neg_im, in_side.ovf_im);

   always_comb begin
      res_in.div_zero = in_side.dz;
      if (in_side.is_div && !in_side.dz) begin
         res_in.res_re = dv_re.val;
         res_in.res_im = dv_im.val;
         res_in.saturated = dv_re.sat || dv_im.sat;
      end else begin
         res_in.res_re = in_side.res_re;
         res_in.res_im = in_side.res_im;
         res_in.saturated = in_side.sat;
      end
   end

   // pipeline moves while the skid stage is empty
   assign en = !skid_valid_ff;
   assign take = in_valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_chan.ready) begin
         out_valid_ff <= skid_valid_ff || take;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_chan.ready) begin
         out_ff <= skid_valid_ff ? skid_ff : res_in;
      end else if (take) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.res_re = out_ff.res_re;
   assign rsp_chan.res_im = out_ff.res_im;
   assign rsp_chan.div_zero = out_ff.div_zero;
   assign rsp_chan.saturated = out_ff.saturated;

endmodule

[src/complex_arith_unit.sv]
// Complex ALU on signed Q16.16 operands: add, subtract, multiply (rounded to nearest, ties
// up) and divide (rounded to nearest, ties away from zero), each part saturated to 32 bits;
// a divide by zero returns the dividend with div_zero set. One transaction is accepted every
// cycle while the skid stage is empty, and each passes through four setup stages (operand
// register, six 32x32 products, product sums, divider setup), a 33-stage restoring divider
// that produces one quotient bit per stage, and an output register. Every operation takes
// the same path so results come out in order. A skid stage behind the output register lets
// one more transaction through while a result waits; req ready drops only when both hold.
module complex_arith_unit import cau_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_chan,
   cau_rsp_if.source rsp_chan
);

   logic     pipe_en;
   logic     prep_valid, div_valid;
   side_type prep_side, div_side;
   lane_type prep_re, prep_im, div_re, div_im;

   cau_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .req_chan  (req_chan),
      .out_valid (prep_valid),
      .out_side  (prep_side),
      .out_re    (prep_re),
      .out_im    (prep_im)
   );

   cau_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (prep_valid),
      .in_side   (prep_side),
      .in_re     (prep_re),
      .in_im     (prep_im),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_re    (div_re),
      .out_im    (div_im)
   );

   cau_out u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (div_valid),
      .in_side  (div_side),
      .in_re    (div_re),
      .in_im    (div_im),
      .en       (pipe_en),
      .rsp_chan (rsp_chan)
   );

   // a stall only happens while a result is on offer
   stall_needs_output: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |-> rsp_chan.valid)
      else $error("pipeline stalled with no result on the output");

   // a stalled pipeline keeps its last transaction
   stall_keeps_item: assert property (@(posedge clock) disable iff (reset)
      !pipe_en && div_valid |=> div_valid)
      else $error("transaction dropped at the end of a stalled pipeline");

   // a zero divisor returns the dividend unclamped
   div_zero_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.div_zero |-> !rsp_chan.saturated)
      else $error("div_zero result flagged as saturated");

endmodule

[tb/cau_checker.sv]
module cau_checker import cau_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cau_req_if        req_chan,
   cau_rsp_if        rsp_chan,
   output int        fail_count,
   output int        pending_count
);

   rsp_type results_due[$];

   function automatic logic [31:0] clamp_part(input logic signed [65:0] v, inout logic sat);
      if (v > 66'sh0_7FFF_FFFF) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -66'sh0_8000_0000) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // nearest, ties toward plus infinity
   function automatic logic signed [65:0] round_q(input logic signed [65:0] v);
      return (v + 66'sd32768) >>> 16;
   endfunction

   // |n| * 2^16 / den, rounded half away from zero, sign applied afterwards
   function automatic logic [31:0] divide_part(input logic signed [65:0] n,
                                              input logic [65:0] den, inout logic sat);
      logic [65:0] mag;
      logic [81:0] q;
      logic [81:0] r;
      logic neg;
      neg = n < 0;
      mag = neg ? -n : n;
      q = ({16'd0, mag} << 16) / {16'd0, den};
      r = ({16'd0, mag} << 16) % {16'd0, den};
      if (2 * r >= {16'd0, den}) q = q + 1;
      if (!neg && q > 82'h7FFF_FFFF) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (neg && q > 82'h8000_0000) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return neg ? 32'(-q) : q[31:0];
   endfunction

   function automatic rsp_type complex_result(input logic [1:0] op,
                                              input logic signed [31:0] a, b, c, d);
      rsp_type r;
      logic sat;
      logic signed [65:0] ac, bd, ad, bc;
      sat = 1'b0;
      r.div_zero = 1'b0;
      ac = a * c;
      bd = b * d;
      ad = a * d;
      bc = b * c;
      case (op)
         OP_ADD: begin
            r.res_re = clamp_part(66'(a) + 66'(c), sat);
            r.res_im = clamp_part(66'(b) + 66'(d), sat);
         end
         OP_SUB: begin
            r.res_re = clamp_part(66'(a) - 66'(c), sat);
            r.res_im = clamp_part(66'(b) - 66'(d), sat);
         end
         OP_MUL: begin
            r.res_re = clamp_part(round_q(ac - bd), sat);
            r.res_im = clamp_part(round_q(ad + bc), sat);
         end
         default: begin
            if (c == 0 && d == 0) begin
               r.div_zero = 1'b1;
               r.res_re = a;
               r.res_im = b;
            end else begin
               r.res_re = divide_part(ac + bd, 66'(c * c) + 66'(d * d), sat);
               r.res_im = divide_part(bc - ad, 66'(c * c) + 66'(d * d), sat);
            end
         end
      endcase
      r.saturated = sat;
      return r;
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result re=%h im=%h", $time, rsp_chan.res_re,
                        rsp_chan.res_im);
               fail_count <= fail_count + 1;
            end else begin
               want = results_due.pop_front();
               if (want.res_re !== rsp_chan.res_re || want.res_im !== rsp_chan.res_im ||
                   want.div_zero !== rsp_chan.div_zero ||
                   want.saturated !== rsp_chan.saturated) begin
                  $display("%0t: mismatch expected re=%h im=%h dz=%b sat=%b",
                           $time, want.res_re, want.res_im, want.div_zero, want.saturated,
                           " actual re=%h im=%h dz=%b sat=%b",
                           rsp_chan.res_re, rsp_chan.res_im, rsp_chan.div_zero,
                           rsp_chan.saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            results_due.push_back(complex_result(req_chan.operation, req_chan.a_re,
                                                 req_chan.a_im, req_chan.b_re, req_chan.b_im));
      end
      pending_count = results_due.size();
   end

endmodule

[tb/complex_arith_unit_test.sv]
module complex_arith_unit_test import cau_pkg::*; ();

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   item_index;
   bit   quiet_phase;
   bit   hold_rsp;

   cau_req_if req_chan();
   cau_rsp_if rsp_chan();

   complex_arith_unit dut(.clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan));

   cau_checker checker_inst(.clock(clock), .reset(reset), .req_chan(req_chan),
                            .rsp_chan(rsp_chan), .fail_count(fail_count),
                            .pending_count(pending_count));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] pick_part();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'd0;
         3: return 32'($signed($urandom_range(0, 8'hFF)) - 128) << 16;
         4: return 32'($urandom_range(0, 20'hFFFFF)) - 32'h8_0000;
         5: return 32'h0001_0000;
         default: return $urandom();
      endcase
   endfunction

   // valid stays high after acceptance so back to back transactions need one update
   task automatic send(input logic [1:0] op, input logic [31:0] a, b, c, d);
      while (!quiet_phase && $urandom_range(0, 99) < 20) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.operation <= op;
      req_chan.a_re <= a;
      req_chan.a_im <= b;
      req_chan.b_re <= c;
      req_chan.b_im <= d;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [1:0] op;
      logic [31:0] c, d;
      op = 2'($urandom_range(0, 3));
      c = pick_part();
      d = pick_part();
      // occasional zero divisor
      if (op == OP_DIV && $urandom_range(0, 19) == 0) begin
         c = 0;
         d = 0;
      end
      send(op, pick_part(), pick_part(), c, d);
   endtask

   // receiver: random stalls, a quiet stretch, and one long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_chan.ready <= 1'b0;
         else if (quiet_phase) rsp_chan.ready <= 1'b1;
         else rsp_chan.ready <= ($urandom_range(0, 99) >= 20);
      end
   end

   initial begin
      hold_rsp = 1'b0;
      wait (item_index == 300);
      hold_rsp = 1'b1;
      repeat (150) @(negedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #3000000;
      $display("FAIL complex_arith_unit");
      $finish;
   end

   initial begin
      int wait_cycles;
      reset = 1'b1;
      quiet_phase = 1'b0;
      item_index = 0;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_ADD;
      req_chan.a_re = 0;
      req_chan.a_im = 0;
      req_chan.b_re = 0;
      req_chan.b_im = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
      send(OP_ADD, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0002_0000);
      send(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      send(OP_SUB, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
      send(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFB_0000);
      send(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      // rounding ties on multiply
      send(OP_MUL, 32'h0000_8000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
      send(OP_MUL, 32'hFFFF_8000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
      send(OP_DIV, 32'h0005_0000, 32'h0007_0000, 32'h0000_0000, 32'h0000_0000);
      send(OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      send(OP_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
      send(OP_DIV, 32'hFFFF_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
      send(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001);
      send(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send(OP_DIV, 32'h0000_0001, 32'h0000_0000, 32'h0000_0002, 32'h0000_0000);
      send(OP_DIV, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
      send(OP_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000);
      req_chan.valid <= 1'b0;
      @(negedge clock);

      // sender pause until every result is back
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 10000) begin
         @(negedge clock);
         wait_cycles++;
      end

      for (item_index = 0; item_index < 840; item_index++) begin
         quiet_phase = (item_index >= 500 && item_index < 650);
         send_random();
      end
      quiet_phase = 1'b0;
      req_chan.valid <= 1'b0;
      @(negedge clock);

      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 20000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (60) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS complex_arith_unit");
      else
         $display("FAIL complex_arith_unit");
      $finish;
   end

endmodule
